>>> design/prc_pkg.sv
// package for the polygon rectangle clipper
// shared constants, register codes and the token control type; no dependencies
`default_nettype none
package prc_pkg;

	localparam int DEF_COORD_BITS = 16;
	localparam int DEF_DEPTH_BITS = 24;
	localparam int DEF_FRAC_BITS  = 16;
	localparam int COLOR_BITS     = 8;
	localparam int CFG_BITS       = 13;
	localparam int NUM_STAGES     = 4;

	localparam logic [CFG_BITS-1:0] FRAME_WIDTH_RST  = 13'd640;
	localparam logic [CFG_BITS-1:0] FRAME_HEIGHT_RST = 13'd480;

	// configuration register indexes
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	// clip edges, in cascade order
	localparam int STAGE_LEFT   = 0;
	localparam int STAGE_TOP    = 1;
	localparam int STAGE_RIGHT  = 2;
	localparam int STAGE_BOTTOM = 3;

	// control part of a token handed from cell to cell
	typedef struct packed {
		logic has_vtx;
		logic close;
	} tok_ctl_t;

endpackage
`default_nettype wire

>>> design/prc_lerp.sv
// interpolation unit: outside + (inside - outside) * t, truncated toward outside
// uses prc_pkg; two registered steps (multiply, then add)
`default_nettype none
module prc_lerp
	import prc_pkg::*;
#(
	parameter int W         = DEF_COORD_BITS,
	parameter bit SGN       = 1'b1,
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 mul_en,
	input  wire logic                 add_en,
	input  wire logic [W-1:0]         o,
	input  wire logic [W-1:0]         i,
	input  wire logic [FRAC_BITS:0]   t,
	output logic      [W-1:0]         res
);

	logic signed [W:0]       oe, ie, d;
	logic                    neg;
	logic [W-1:0]            mag;
	logic [W+FRAC_BITS:0]    prod;
	logic [W:0]              p_s1;
	logic                    neg_s1;
	logic signed [W:0]       o_s1;
	logic [W+1:0]            sum;
	logic [W-1:0]            res_q;
	logic [W:0]              negd;

	assign oe   = SGN ? {o[W-1], o} : {1'b0, o};
	assign ie   = SGN ? {i[W-1], i} : {1'b0, i};
	assign d    = ie - oe;
	assign neg  = d[W];
	assign negd = -d;
	assign mag  = neg ? negd[W-1:0] : d[W-1:0];
	assign prod = (W+FRAC_BITS+1)'(mag) * (W+FRAC_BITS+1)'(t);

	always_ff @(posedge clk) begin
		if (mul_en) begin
			p_s1   <= prod[W+FRAC_BITS:FRAC_BITS];
			neg_s1 <= neg;
			o_s1   <= oe;
		end
	end

	assign sum = neg_s1 ? ({o_s1[W], o_s1} - {1'b0, p_s1})
	                    : ({o_s1[W], o_s1} + {1'b0, p_s1});

	always_ff @(posedge clk) begin
		if (add_en) begin
			res_q <= sum[W-1:0];
		end
	end

	assign res = res_q;

endmodule
`default_nettype wire

>>> design/prc_cell.sv
// one clip cell: clips the vertex stream against a single frame edge
// uses prc_pkg and prc_lerp; serial divider for the edge fraction
`default_nettype none
module prc_cell
	import prc_pkg::*;
#(
	parameter int COORD_BITS = DEF_COORD_BITS,
	parameter int DEPTH_BITS = DEF_DEPTH_BITS,
	parameter int FRAC_BITS  = DEF_FRAC_BITS,
	parameter int STAGE      = STAGE_LEFT,
	localparam int VW        = 2*COORD_BITS + DEPTH_BITS + 3*COLOR_BITS
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [CFG_BITS-1:0] limit,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [VW-1:0]       in_vtx,
	input  wire tok_ctl_t            in_ctl,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic      [VW-1:0]       out_vtx,
	output tok_ctl_t                 out_ctl
);

	localparam int  EW   = ((COORD_BITS > CFG_BITS + 1) ? COORD_BITS : CFG_BITS + 1) + 1;
	localparam int  MW   = EW + 1;
	localparam int  RW   = MW + 1;
	localparam int  TW   = FRAC_BITS + 1;
	localparam int  CNTW = $clog2(TW);
	localparam bit  ON_X = (STAGE == STAGE_LEFT) || (STAGE == STAGE_RIGHT);
	localparam bit  IS_MAX = (STAGE == STAGE_TOP) || (STAGE == STAGE_RIGHT);
	localparam int  ZO   = 3*COLOR_BITS;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CLOSE = 4'd1;
	localparam logic [3:0] ST_EDGE  = 4'd2;
	localparam logic [3:0] ST_DIV   = 4'd3;
	localparam logic [3:0] ST_MUL   = 4'd4;
	localparam logic [3:0] ST_ADD   = 4'd5;
	localparam logic [3:0] ST_OUTI  = 4'd6;
	localparam logic [3:0] ST_OUTV  = 4'd7;
	localparam logic [3:0] ST_FWD   = 4'd8;

	logic [3:0]      state_q;
	logic            started_q, close_q, cedge_q, emitv_q;
	logic [VW-1:0]   first_q, prev_q, p1_q, p2_q, o_q, i_q;
	logic [RW-1:0]   rem_q;
	logic [MW-1:0]   ud_q;
	logic [TW-1:0]   t_q;
	logic [CNTW-1:0] cnt_q;

	logic signed [EW-1:0] lim_e, c_e;
	logic                 in1, in2;
	logic [3:0]           done_st;

	// edge test on one vertex
	function automatic logic inside_f(input logic [VW-1:0] v, input logic signed [EW-1:0] lim);
		logic signed [EW-1:0] xe, ye;
		xe = {{(EW-COORD_BITS){v[VW-1]}}, v[VW-1 -: COORD_BITS]};
		ye = {{(EW-COORD_BITS){v[VW-1-COORD_BITS]}}, v[VW-1-COORD_BITS -: COORD_BITS]};
		case (STAGE)
			STAGE_LEFT:  inside_f = !xe[EW-1];
			STAGE_TOP:   inside_f = ye < lim;
			STAGE_RIGHT: inside_f = xe < lim;
			default:     inside_f = !ye[EW-1];
		endcase
	endfunction

	// coordinate across the edge, sign extended
	function automatic logic signed [EW-1:0] axis_f(input logic [VW-1:0] v);
		logic [COORD_BITS-1:0] a;
		a = ON_X ? v[VW-1 -: COORD_BITS] : v[VW-1-COORD_BITS -: COORD_BITS];
		axis_f = {{(EW-COORD_BITS){a[COORD_BITS-1]}}, a};
	endfunction

	function automatic logic [MW-1:0] absdiff_f(input logic signed [EW-1:0] a,
		input logic signed [EW-1:0] b);
		logic signed [EW:0] df;
		df = {a[EW-1], a} - {b[EW-1], b};
		absdiff_f = df[EW] ? MW'(-df) : MW'(df);
	endfunction

	assign lim_e = {{(EW-CFG_BITS){1'b0}}, limit};
	assign c_e   = IS_MAX ? (lim_e - EW'(1)) : '0;
	assign in1   = inside_f(p1_q, lim_e);
	assign in2   = inside_f(p2_q, lim_e);
	assign done_st = cedge_q ? ST_FWD : ST_CLOSE;

	// divider step
	logic          div_ge;
	logic [MW-1:0] div_sub;
	assign div_ge  = rem_q >= {1'b0, ud_q};
	assign div_sub = div_ge ? MW'(rem_q - {1'b0, ud_q}) : rem_q[MW-1:0];

	// interpolators
	logic                  mul_en, add_en;
	logic [COORD_BITS-1:0] oth_o, oth_i, oth_r;
	logic [DEPTH_BITS-1:0] z_r;
	logic [COLOR_BITS-1:0] r_r, g_r, b_r;

	assign mul_en = state_q == ST_MUL;
	assign add_en = state_q == ST_ADD;
	assign oth_o  = ON_X ? o_q[VW-1-COORD_BITS -: COORD_BITS] : o_q[VW-1 -: COORD_BITS];
	assign oth_i  = ON_X ? i_q[VW-1-COORD_BITS -: COORD_BITS] : i_q[VW-1 -: COORD_BITS];

	prc_lerp #(.W(COORD_BITS), .SGN(1'b1), .FRAC_BITS(FRAC_BITS)) u_lerp_c (
		.clk(clk), .mul_en(mul_en), .add_en(add_en),
		.o(oth_o), .i(oth_i), .t(t_q), .res(oth_r)
	);
	prc_lerp #(.W(DEPTH_BITS), .SGN(1'b1), .FRAC_BITS(FRAC_BITS)) u_lerp_z (
		.clk(clk), .mul_en(mul_en), .add_en(add_en),
		.o(o_q[ZO +: DEPTH_BITS]), .i(i_q[ZO +: DEPTH_BITS]), .t(t_q), .res(z_r)
	);
	prc_lerp #(.W(COLOR_BITS), .SGN(1'b0), .FRAC_BITS(FRAC_BITS)) u_lerp_r (
		.clk(clk), .mul_en(mul_en), .add_en(add_en),
		.o(o_q[2*COLOR_BITS +: COLOR_BITS]), .i(i_q[2*COLOR_BITS +: COLOR_BITS]),
		.t(t_q), .res(r_r)
	);
	prc_lerp #(.W(COLOR_BITS), .SGN(1'b0), .FRAC_BITS(FRAC_BITS)) u_lerp_g (
		.clk(clk), .mul_en(mul_en), .add_en(add_en),
		.o(o_q[COLOR_BITS +: COLOR_BITS]), .i(i_q[COLOR_BITS +: COLOR_BITS]),
		.t(t_q), .res(g_r)
	);
	prc_lerp #(.W(COLOR_BITS), .SGN(1'b0), .FRAC_BITS(FRAC_BITS)) u_lerp_b (
		.clk(clk), .mul_en(mul_en), .add_en(add_en),
		.o(o_q[0 +: COLOR_BITS]), .i(i_q[0 +: COLOR_BITS]), .t(t_q), .res(b_r)
	);

	logic [VW-1:0]         ivtx;
	logic [COORD_BITS-1:0] c_c;
	assign c_c  = c_e[COORD_BITS-1:0];
	assign ivtx = ON_X ? {c_c, oth_r, z_r, r_r, g_r, b_r} : {oth_r, c_c, z_r, r_r, g_r, b_r};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			started_q <= 1'b0;
			close_q   <= 1'b0;
			cedge_q   <= 1'b0;
			emitv_q   <= 1'b0;
			cnt_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						close_q <= in_ctl.close;
						if (in_ctl.has_vtx && started_q) begin
							cedge_q <= 1'b0;
							state_q <= ST_EDGE;
						end else begin
							state_q <= ST_CLOSE;
							if (in_ctl.has_vtx) begin
								started_q <= 1'b1;
							end
						end
					end
				end
				ST_CLOSE: begin
					if (close_q && started_q) begin
						started_q <= 1'b0;
						cedge_q   <= 1'b1;
						state_q   <= ST_EDGE;
					end else if (close_q) begin
						state_q <= ST_FWD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EDGE: begin
					cnt_q <= '0;
					if (in1 && in2) begin
						state_q <= ST_OUTV;
					end else if (in1 || in2) begin
						emitv_q <= in2;
						state_q <= ST_DIV;
					end else begin
						state_q <= done_st;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CNTW'(1);
					if (cnt_q == CNTW'(TW-1)) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL:  state_q <= ST_ADD;
				ST_ADD:  state_q <= ST_OUTI;
				ST_OUTI: begin
					if (!out_stall) begin
						state_q <= emitv_q ? ST_OUTV : done_st;
					end
				end
				ST_OUTV: begin
					if (!out_stall) begin
						state_q <= done_st;
					end
				end
				ST_FWD: begin
					if (!out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// vertex and divider datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ctl.has_vtx) begin
					prev_q <= in_vtx;
					p1_q   <= prev_q;
					p2_q   <= in_vtx;
					if (!started_q) begin
						first_q <= in_vtx;
					end
				end
			end
			ST_CLOSE: begin
				p1_q <= prev_q;
				p2_q <= first_q;
			end
			ST_EDGE: begin
				o_q   <= in1 ? p2_q : p1_q;
				i_q   <= in1 ? p1_q : p2_q;
				rem_q <= RW'(in1 ? absdiff_f(c_e, axis_f(p2_q)) : absdiff_f(c_e, axis_f(p1_q)));
				ud_q  <= absdiff_f(axis_f(p1_q), axis_f(p2_q));
				t_q   <= '0;
			end
			ST_DIV: begin
				t_q   <= {t_q[TW-2:0], div_ge};
				rem_q <= {div_sub, 1'b0};
			end
			default: ;
		endcase
	end

	assign in_stall        = state_q != ST_IDLE;
	assign out_valid       = (state_q == ST_OUTI) || (state_q == ST_OUTV) || (state_q == ST_FWD);
	assign out_vtx         = (state_q == ST_OUTI) ? ivtx : p2_q;
	assign out_ctl.has_vtx = state_q != ST_FWD;
	assign out_ctl.close   = state_q == ST_FWD;

endmodule
`default_nettype wire

>>> design/prc_sink.sv
// output cell: holds one clipped vertex back so the final one can be marked
// uses prc_pkg; drives the result register of the block
`default_nettype none
module prc_sink
	import prc_pkg::*;
#(
	parameter int COORD_BITS = DEF_COORD_BITS,
	parameter int DEPTH_BITS = DEF_DEPTH_BITS,
	localparam int VW        = 2*COORD_BITS + DEPTH_BITS + 3*COLOR_BITS
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic [VW-1:0] in_vtx,
	input  wire tok_ctl_t      in_ctl,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic      [VW-1:0] out_vtx,
	output logic               out_last,
	output logic               out_empty
);

	logic          hold_valid_q, ovalid_q, olast_q, oempty_q;
	logic [VW-1:0] hold_q, ovtx_q;
	logic          acc;

	assign in_stall = ovalid_q && out_stall;
	assign acc      = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			ovalid_q     <= 1'b0;
		end else begin
			if (acc && in_ctl.has_vtx) begin
				hold_valid_q <= 1'b1;
				ovalid_q     <= hold_valid_q;
			end else if (acc) begin
				hold_valid_q <= 1'b0;
				ovalid_q     <= 1'b1;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && in_ctl.has_vtx) begin
			hold_q   <= in_vtx;
			ovtx_q   <= hold_q;
			olast_q  <= 1'b0;
			oempty_q <= 1'b0;
		end else if (acc) begin
			ovtx_q   <= hold_valid_q ? hold_q : '0;
			olast_q  <= 1'b1;
			oempty_q <= !hold_valid_q;
		end
	end

	assign out_valid = ovalid_q;
	assign out_vtx   = ovtx_q;
	assign out_last  = olast_q;
	assign out_empty = oempty_q;

endmodule
`default_nettype wire

>>> design/polygon_rect_clipper.sv
// top level of the polygon rectangle clipper
// uses prc_pkg, prc_cell, prc_sink; chain of four clip cells and an output cell
`default_nettype none
// Streaming polygon clipper against the frame rectangle 0 <= x < frame_width,
// 0 <= y < frame_height. Vertices enter one per transfer, vert_last closes the
// polygon. Four clip cells (left, top, right, bottom) form a chain; each keeps
// the first and previous vertex of its polygon and hands clipped vertices to
// its neighbor. Crossing points lie on the edge (width or height minus one on
// the far edges); the other coordinate, depth and color are interpolated by the
// fraction along the edge. Each result is held back by one clipped vertex so
// the final one can carry out_last; a polygon with nothing left yields a single
// result with out_empty and out_last set. In a cell, a vertex that crosses the
// edge runs the bit-serial divider for the edge fraction, then the multiply and
// add, and the cell takes no new vertex until it is through; a closing vertex
// runs the closing edge too. Cells work concurrently on successive vertices.
// Configuration is written through cfg_we / cfg_idx / cfg_data; the user must
// write it only while the block is idle, which the block itself does not enforce.
module polygon_rect_clipper
	import prc_pkg::*;
#(
	parameter int COORD_BITS = DEF_COORD_BITS,
	parameter int DEPTH_BITS = DEF_DEPTH_BITS,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// configuration writes
	input  wire logic                         cfg_we,
	input  wire logic                         cfg_idx,
	input  wire logic [CFG_BITS-1:0]          cfg_data,
	// vertex input
	input  wire logic                         vert_valid,
	output logic                              vert_stall,
	input  wire logic signed [COORD_BITS-1:0] vert_x,
	input  wire logic signed [COORD_BITS-1:0] vert_y,
	input  wire logic signed [DEPTH_BITS-1:0] vert_z,
	input  wire logic [COLOR_BITS-1:0]        vert_red,
	input  wire logic [COLOR_BITS-1:0]        vert_green,
	input  wire logic [COLOR_BITS-1:0]        vert_blue,
	input  wire logic                         vert_last,
	// clipped vertex output
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic signed [COORD_BITS-1:0]      out_x,
	output logic signed [COORD_BITS-1:0]      out_y,
	output logic signed [DEPTH_BITS-1:0]      out_z,
	output logic [COLOR_BITS-1:0]             out_red,
	output logic [COLOR_BITS-1:0]             out_green,
	output logic [COLOR_BITS-1:0]             out_blue,
	output logic                              out_last,
	output logic                              out_empty
);

	localparam int VW = 2*COORD_BITS + DEPTH_BITS + 3*COLOR_BITS;

	// frame size registers
	logic [CFG_BITS-1:0] frame_width_q, frame_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// token links: index 0 is the input, index NUM_STAGES feeds the output cell
	logic          lk_valid [NUM_STAGES+1];
	logic          lk_stall [NUM_STAGES+1];
	logic [VW-1:0] lk_vtx   [NUM_STAGES+1];
	tok_ctl_t      lk_ctl   [NUM_STAGES+1];

	// an input vertex carries its own close request
	assign lk_valid[0]       = vert_valid;
	assign vert_stall        = lk_stall[0];
	assign lk_vtx[0]         = {vert_x, vert_y, vert_z, vert_red, vert_green, vert_blue};
	assign lk_ctl[0].has_vtx = 1'b1;
	assign lk_ctl[0].close   = vert_last;

	for (genvar s = 0; s < NUM_STAGES; s++) begin : g_cell
		// top cell clips on height, the others on width (left and bottom ignore it)
		prc_cell #(
			.COORD_BITS(COORD_BITS),
			.DEPTH_BITS(DEPTH_BITS),
			.FRAC_BITS (FRAC_BITS),
			.STAGE     (s)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.limit    ((s == STAGE_TOP) ? frame_height_q : frame_width_q),
			.in_valid (lk_valid[s]),
			.in_stall (lk_stall[s]),
			.in_vtx   (lk_vtx[s]),
			.in_ctl   (lk_ctl[s]),
			.out_valid(lk_valid[s+1]),
			.out_stall(lk_stall[s+1]),
			.out_vtx  (lk_vtx[s+1]),
			.out_ctl  (lk_ctl[s+1])
		);
	end

	logic [VW-1:0] res_vtx;

	prc_sink #(
		.COORD_BITS(COORD_BITS),
		.DEPTH_BITS(DEPTH_BITS)
	) u_sink (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (lk_valid[NUM_STAGES]),
		.in_stall (lk_stall[NUM_STAGES]),
		.in_vtx   (lk_vtx[NUM_STAGES]),
		.in_ctl   (lk_ctl[NUM_STAGES]),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_vtx  (res_vtx),
		.out_last (out_last),
		.out_empty(out_empty)
	);

	// unpack the result vertex
	assign out_x     = res_vtx[VW-1 -: COORD_BITS];
	assign out_y     = res_vtx[VW-1-COORD_BITS -: COORD_BITS];
	assign out_z     = res_vtx[3*COLOR_BITS +: DEPTH_BITS];
	assign out_red   = res_vtx[2*COLOR_BITS +: COLOR_BITS];
	assign out_green = res_vtx[COLOR_BITS +: COLOR_BITS];
	assign out_blue  = res_vtx[0 +: COLOR_BITS];

endmodule
`default_nettype wire

>>> design/prc_checker.sv
// port checker for the polygon rectangle clipper
// depends on polygon_rect_clipper ports only; bound to the top level below
`default_nettype none
module prc_checker
	import prc_pkg::*;
#(
	parameter int COORD_BITS = DEF_COORD_BITS,
	parameter int DEPTH_BITS = DEF_DEPTH_BITS
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  out_valid,
	input wire logic                  out_stall,
	input wire logic [COORD_BITS-1:0] out_x,
	input wire logic [COORD_BITS-1:0] out_y,
	input wire logic [DEPTH_BITS-1:0] out_z,
	input wire logic [COLOR_BITS-1:0] out_red,
	input wire logic                  out_last,
	input wire logic                  out_empty
);

	// an empty polygon result always closes the polygon
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_empty |-> out_last)
		else $error("empty result without last");

	// an empty polygon result carries zero x, y, depth and red fields
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_empty |-> (out_x == '0) && (out_y == '0) && (out_z == '0)
			&& (out_red == '0))
		else $error("empty result with nonzero fields");

	// a stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its x, y and last flag
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_x) && $stable(out_y) && $stable(out_last))
		else $error("result changed while stalled");

endmodule

bind polygon_rect_clipper prc_checker #(
	.COORD_BITS(COORD_BITS),
	.DEPTH_BITS(DEPTH_BITS)
) u_prc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_x    (out_x),
	.out_y    (out_y),
	.out_z    (out_z),
	.out_red  (out_red),
	.out_last (out_last),
	.out_empty(out_empty)
);
`default_nettype wire

>>> tb/tb_polygon_rect_clipper.sv
// testbench for the polygon rectangle clipper
// predicts clipped vertices with its own clip chain model; depends on prc_pkg and the rtl
`timescale 1ns / 1ps
`default_nettype none
module tb_polygon_rect_clipper;
	import prc_pkg::*;

	localparam int CB = DEF_COORD_BITS;
	localparam int DB = DEF_DEPTH_BITS;
	localparam int FB = DEF_FRAC_BITS;
	localparam longint CYCLE_LIMIT = 2000000;

	// one vertex as the predictor carries it, wide enough for any intermediate
	typedef struct {
		longint x, y, z, r, g, b;
	} vtx_t;

	// one expected or observed result
	typedef struct packed {
		logic signed [CB-1:0] x;
		logic signed [CB-1:0] y;
		logic signed [DB-1:0] z;
		logic [7:0]           r, g, b;
		logic                 last, empty;
	} clip_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_idx = 1'b0;
	logic [CFG_BITS-1:0] cfg_data = '0;
	logic vert_valid = 1'b0;
	logic vert_stall;
	logic signed [CB-1:0] vert_x = '0, vert_y = '0;
	logic signed [DB-1:0] vert_z = '0;
	logic [7:0] vert_red = '0, vert_green = '0, vert_blue = '0;
	logic vert_last = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [CB-1:0] out_x, out_y;
	logic signed [DB-1:0] out_z;
	logic [7:0] out_red, out_green, out_blue;
	logic out_last, out_empty;

	polygon_rect_clipper u_top (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state: frame size, per-edge first/prev vertex, output hold register
	longint    frame_w = 640, frame_h = 480;
	vtx_t      edge_first[NUM_STAGES], edge_prev[NUM_STAGES];
	bit        edge_open[NUM_STAGES];
	int        clipped_cnt;
	vtx_t      held_vtx;
	bit        held_ok;
	clip_res_t step_buf[$];
	clip_res_t expected_verts[$];

	int  mismatches = 0;
	longint cycles = 0;
	int  send_idle_pct = 0, recv_stall_pct = 0;

	function automatic bit keeps(int s, vtx_t v);
		case (s)
			STAGE_LEFT:  return v.x >= 0;
			STAGE_TOP:   return v.y < frame_h;
			STAGE_RIGHT: return v.x < frame_w;
			default:     return v.y >= 0;
		endcase
	endfunction

	function automatic longint blend(longint a, longint b, longint t);
		longint d, p;
		d = b - a;
		p = ((d < 0 ? -d : d) * t) >>> FB;
		return d < 0 ? a - p : a + p;
	endfunction

	// crossing of outside vertex o toward inside vertex i with edge s
	function automatic vtx_t crossing(int s, vtx_t o, vtx_t i);
		vtx_t c;
		bit on_x;
		longint e, oa, ia, n, d, t;
		on_x = (s == STAGE_LEFT || s == STAGE_RIGHT);
		e = (s == STAGE_LEFT || s == STAGE_BOTTOM) ? 0 :
			((s == STAGE_TOP) ? frame_h : frame_w) - 1;
		oa = on_x ? o.x : o.y;
		ia = on_x ? i.x : i.y;
		n = e - oa;
		d = ia - oa;
		if (n < 0) n = -n;
		if (d < 0) d = -d;
		t = (d == 0) ? 0 : ((n << FB) / d);
		if (t > (64'sd1 << FB)) t = 64'sd1 << FB;
		if (on_x) begin
			c.x = e;
			c.y = blend(o.y, i.y, t);
		end else begin
			c.y = e;
			c.x = blend(o.x, i.x, t);
		end
		c.z = blend(o.z, i.z, t);
		c.r = blend(o.r, i.r, t);
		c.g = blend(o.g, i.g, t);
		c.b = blend(o.b, i.b, t);
		return c;
	endfunction

	function automatic void record(vtx_t v, bit last, bit empty, bit closing);
		clip_res_t r;
		r.x = v.x[CB-1:0];
		r.y = v.y[CB-1:0];
		r.z = v.z[DB-1:0];
		r.r = v.r[7:0];
		r.g = v.g[7:0];
		r.b = v.b[7:0];
		r.last = last;
		r.empty = empty;
		if (step_buf.size() >= 16) begin
			if (closing) step_buf[15] = r;
		end else begin
			step_buf = {step_buf, r};
		end
	endfunction

	function automatic void emit_vertex(vtx_t v);
		if (clipped_cnt < 16'hffff) clipped_cnt++;
		if (held_ok) record(held_vtx, 0, 0, 0);
		held_vtx = v;
		held_ok = 1;
	endfunction

	function automatic void clip_push(int s, vtx_t v);
		vtx_t p;
		bit in_p, in_v;
		if (s >= NUM_STAGES) begin
			emit_vertex(v);
			return;
		end
		if (!edge_open[s]) begin
			edge_first[s] = v;
			edge_prev[s] = v;
			edge_open[s] = 1;
			return;
		end
		p = edge_prev[s];
		edge_prev[s] = v;
		in_p = keeps(s, p);
		in_v = keeps(s, v);
		if (in_p && in_v) clip_push(s + 1, v);
		else if (!in_p && in_v) begin
			clip_push(s + 1, crossing(s, p, v));
			clip_push(s + 1, v);
		end else if (in_p && !in_v) clip_push(s + 1, crossing(s, v, p));
	endfunction

	function automatic void clip_close(int s);
		vtx_t p, f, zero_v;
		bit in_p, in_f;
		if (s >= NUM_STAGES) begin
			zero_v = '{default: 0};
			if (held_ok && clipped_cnt != 0) record(held_vtx, 1, 0, 1);
			else record(zero_v, 1, 1, 1);
			held_ok = 0;
			clipped_cnt = 0;
			return;
		end
		if (edge_open[s]) begin
			p = edge_prev[s];
			f = edge_first[s];
			edge_open[s] = 0;
			in_p = keeps(s, p);
			in_f = keeps(s, f);
			if (in_p && in_f) clip_push(s + 1, f);
			else if (!in_p && in_f) begin
				clip_push(s + 1, crossing(s, p, f));
				clip_push(s + 1, f);
			end else if (in_p && !in_f) clip_push(s + 1, crossing(s, f, p));
		end
		clip_close(s + 1);
	endfunction

	function automatic void predict_vertex(vtx_t v, bit last);
		step_buf.delete();
		clip_push(0, v);
		if (last) clip_close(0);
		foreach (step_buf[k]) expected_verts = {expected_verts, step_buf[k]};
	endfunction

	// send one vertex, holding the payload until the transfer completes;
	// valid stays high for a following vertex and is dropped by idling or drain
	task automatic send_vertex(longint x, longint y, longint z, int r, int g, int b, bit last);
		vtx_t v;
		while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
			vert_valid <= 1'b0;
			@(negedge clk);
		end
		vert_valid <= 1'b1;
		vert_x <= x[CB-1:0];
		vert_y <= y[CB-1:0];
		vert_z <= z[DB-1:0];
		vert_red <= r[7:0];
		vert_green <= g[7:0];
		vert_blue <= b[7:0];
		vert_last <= last;
		do @(posedge clk); while (vert_stall);
		v.x = $signed(x[CB-1:0]);
		v.y = $signed(y[CB-1:0]);
		v.z = $signed(z[DB-1:0]);
		v.r = r[7:0];
		v.g = g[7:0];
		v.b = b[7:0];
		predict_vertex(v, last);
		@(negedge clk);
	endtask

	// wait until every predicted result came out, then let the chain settle
	task automatic drain();
		vert_valid <= 1'b0;
		while (expected_verts.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task automatic write_frame(logic idx, int value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= value[CFG_BITS-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_FRAME_WIDTH) frame_w = value[CFG_BITS-1:0];
		else frame_h = value[CFG_BITS-1:0];
	endtask

	task automatic send_poly(int n, int spread);
		for (int k = 0; k < n; k++)
			send_vertex($signed($urandom_range(2 * spread, 0)) - spread / 2,
				$signed($urandom_range(2 * spread, 0)) - spread / 2,
				$signed($urandom) >>> 8, $urandom_range(255, 0),
				$urandom_range(255, 0), $urandom_range(255, 0), k == n - 1);
	endtask

	// extremes of every field, inside, crossing, single vertex, fully clipped
	task automatic test_directed();
		send_vertex(10, 10, 100, 1, 2, 3, 0);
		send_vertex(100, 10, -100, 255, 0, 128, 0);
		send_vertex(50, 100, 0, 0, 255, 7, 1);
		// single vertex inside and outside
		send_vertex(5, 5, 8388607, 255, 255, 255, 1);
		send_vertex(-5, 5, -8388608, 0, 0, 0, 1);
		// fully clipped, both vertices below the frame
		send_vertex(-32768, -32768, 0, 0, 0, 0, 0);
		send_vertex(32767, -32768, 1, 1, 1, 1, 1);
		// crossing every edge, including full range coordinates
		send_vertex(-32768, 240, -8388608, 0, 0, 0, 0);
		send_vertex(320, 32767, 8388607, 255, 255, 255, 0);
		send_vertex(32767, 240, 12345, 170, 85, 15, 0);
		send_vertex(320, -32768, -54321, 85, 170, 240, 1);
		// star shape crossing edges many times
		send_vertex(-100, -100, 0, 10, 20, 30, 0);
		send_vertex(700, 500, 1000, 200, 100, 50, 0);
		send_vertex(-100, 500, 2000, 0, 255, 0, 0);
		send_vertex(700, -100, -3000, 255, 0, 255, 0);
		send_vertex(320, 240, 4, 4, 4, 4, 0);
		send_vertex(-32768, 32767, 5, 5, 5, 5, 1);
	endtask

	// random polygons, mostly around the frame, some anywhere
	task automatic test_random(int polys);
		for (int p = 0; p < polys; p++) begin
			if ($urandom_range(9, 0) == 0)
				send_poly($urandom_range(6, 1), 65535);
			else
				send_poly($urandom_range(7, 1), $urandom_range(1, 0) ? 1400 : 40);
		end
	endtask

	task automatic test_frames();
		drain();
		write_frame(REG_FRAME_WIDTH, 1);
		write_frame(REG_FRAME_HEIGHT, 1);
		test_random(3);
		drain();
		write_frame(REG_FRAME_WIDTH, 4096);
		write_frame(REG_FRAME_HEIGHT, 4096);
		send_poly(4, 65535);
		test_random(3);
		drain();
		// a width with the high bit set and a zero height clip everything
		write_frame(REG_FRAME_WIDTH, 8191);
		write_frame(REG_FRAME_HEIGHT, 0);
		test_random(2);
		drain();
		write_frame(REG_FRAME_WIDTH, 33);
		write_frame(REG_FRAME_HEIGHT, 17);
		test_random(4);
		drain();
	endtask

	// result checker: compares each transfer with the oldest expectation
	always @(posedge clk) begin
		clip_res_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = {out_x, out_y, out_z, out_red, out_green, out_blue, out_last, out_empty};
			if (expected_verts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", got);
			end else begin
				want = expected_verts.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p actual %p", want, got);
				end
			end
		end
	end

	// random receiver stall, changed at the falling edge
	always @(negedge clk)
		out_stall <= recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct;

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(8);
		drain();
		// pause until all results drained, then idle phases
		send_idle_pct = 50;
		test_random(6);
		send_idle_pct = 0;
		recv_stall_pct = 50;
		test_random(6);
		send_idle_pct = 20;
		recv_stall_pct = 20;
		test_random(6);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_frames();
		drain();
		if (mismatches == 0 && expected_verts.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
`default_nettype wire

>>> polygon_rect_clipper.f
design/prc_pkg.sv
design/prc_lerp.sv
design/prc_cell.sv
design/prc_sink.sv
design/polygon_rect_clipper.sv
design/prc_checker.sv
tb/tb_polygon_rect_clipper.sv
